// File: rtl/hrbp_pkg.sv
// Shared types, codes and character helpers for the HTTP request byte parser.
// No dependencies; used by every module of the block.

package hrbp_pkg;

  // Field tags carried on byte_field and field_closed
  localparam logic [3:0] FieldNone     = 4'd0;
  localparam logic [3:0] FieldMethod   = 4'd1;
  localparam logic [3:0] FieldUrl      = 4'd2;
  localparam logic [3:0] FieldQkey     = 4'd3;
  localparam logic [3:0] FieldQvalue   = 4'd4;
  localparam logic [3:0] FieldProtocol = 4'd5;
  localparam logic [3:0] FieldVersion  = 4'd6;
  localparam logic [3:0] FieldHkey     = 4'd7;
  localparam logic [3:0] FieldHvalue   = 4'd8;
  localparam logic [3:0] FieldBody     = 4'd9;

  // Parse status codes
  localparam logic [2:0] StatusParsing       = 3'd0;
  localparam logic [2:0] StatusComplete      = 3'd1;
  localparam logic [2:0] StatusInvalid       = 3'd2;
  localparam logic [2:0] StatusInvalidMethod = 3'd3;
  localparam logic [2:0] StatusInvalidUrl    = 3'd4;

  // Delimiter characters
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;

  // Length of the "Content-Length" key
  localparam logic [3:0] KeyLen = 4'd14;

  // Number scan phases of the length value
  typedef enum logic [1:0] {
    ScanSkip    = 2'd0,
    ScanDigits  = 2'd1,
    ScanStopped = 2'd2
  } scan_phase_t;

  // Header tracker requests from the phase logic
  typedef struct packed {
    logic restart;
    logic key_first;
    logic key_char;
    logic key_colon;
    logic value_char;
  } hdr_ctl_t;

  // Header tracker state seen by the phase logic
  typedef struct packed {
    logic seen;
    logic positive;
  } hdr_stat_t;

  // Characters of "Content-Length" by position
  function automatic logic [7:0] length_key(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// File: rtl/hrbp_hdr_track.sv
// Content-Length key matcher and positive-value scanner.
// Depends on hrbp_pkg; driven by requests from hrbp_phase.

module hrbp_hdr_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  hrbp_pkg::hdr_ctl_t  ctl,
  output hrbp_pkg::hdr_stat_t stat
);

  logic                      key_matches;
  logic                      key_matches_next;
  logic [3:0]                key_idx;
  logic [3:0]                key_idx_next;
  logic                      seen;
  logic                      seen_next;
  logic                      positive;
  logic                      positive_next;
  hrbp_pkg::scan_phase_t     scan;
  hrbp_pkg::scan_phase_t     scan_next;
  logic                      colon_match;

  assign colon_match = key_matches && (key_idx == hrbp_pkg::KeyLen);

  // Work out the next match and scan state for this beat
  always_comb begin
    key_matches_next = key_matches;
    key_idx_next     = key_idx;
    seen_next        = seen;
    positive_next    = positive;
    scan_next        = scan;
    if (ctl.restart) begin
      key_matches_next = 1'b0;
      key_idx_next     = 4'd0;
      seen_next        = 1'b0;
      positive_next    = 1'b0;
      scan_next        = hrbp_pkg::ScanSkip;
    end else if (ctl.key_first) begin
      key_matches_next = (data_byte == hrbp_pkg::length_key(4'd0));
      key_idx_next     = 4'd1;
    end else if (ctl.key_char) begin
      if (key_matches && (key_idx < hrbp_pkg::KeyLen) &&
          (data_byte == hrbp_pkg::length_key(key_idx))) begin
        key_idx_next = key_idx + 4'd1;
      end else begin
        key_matches_next = 1'b0;
      end
    end else if (ctl.key_colon) begin
      key_matches_next = colon_match;
      if (colon_match) begin
        seen_next     = 1'b1;
        positive_next = 1'b0;
        scan_next     = hrbp_pkg::ScanSkip;
      end
    end else if (ctl.value_char && key_matches) begin
      // atoi-style scan: white space, optional plus, then digits
      case (scan)
        hrbp_pkg::ScanSkip: begin
          if (hrbp_pkg::is_space(data_byte)) begin
            scan_next = hrbp_pkg::ScanSkip;
          end else if (data_byte == hrbp_pkg::ChPlus) begin
            scan_next = hrbp_pkg::ScanDigits;
          end else if (hrbp_pkg::is_digit(data_byte)) begin
            scan_next = hrbp_pkg::ScanDigits;
            if (data_byte != hrbp_pkg::ChZero) positive_next = 1'b1;
          end else begin
            scan_next = hrbp_pkg::ScanStopped;
          end
        end
        hrbp_pkg::ScanDigits: begin
          if (hrbp_pkg::is_digit(data_byte)) begin
            if (data_byte != hrbp_pkg::ChZero) positive_next = 1'b1;
          end else begin
            scan_next = hrbp_pkg::ScanStopped;
          end
        end
        default: scan_next = scan;
      endcase
    end
  end

  // Hold tracker state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      key_matches <= 1'b0;
      key_idx     <= 4'd0;
      seen        <= 1'b0;
      positive    <= 1'b0;
      scan        <= hrbp_pkg::ScanSkip;
    end else if (fire) begin
      key_matches <= key_matches_next;
      key_idx     <= key_idx_next;
      seen        <= seen_next;
      positive    <= positive_next;
      scan        <= scan_next;
    end
  end

  assign stat.seen     = seen;
  assign stat.positive = positive;

endmodule

// File: rtl/hrbp_phase.sv
// Request parse state machine: tags each byte and sets the parse status.
// Depends on hrbp_pkg; issues requests to hrbp_hdr_track.

module hrbp_phase (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                restart,
  input  logic [7:0]          data_byte,
  input  logic                buffer_last,
  input  hrbp_pkg::hdr_stat_t hdr_stat,
  output hrbp_pkg::hdr_ctl_t  hdr_ctl,
  output logic [3:0]          byte_field,
  output logic [3:0]          field_closed,
  output logic [2:0]          parse_status,
  output logic                body_follows
);

  typedef enum logic [4:0] {
    PhStart          = 5'd0,
    PhMethod         = 5'd1,
    PhBeforeUrl      = 5'd2,
    PhUrl            = 5'd3,
    PhBeforeQkey     = 5'd4,
    PhQkey           = 5'd5,
    PhBeforeQvalue   = 5'd6,
    PhQvalue         = 5'd7,
    PhBeforeProtocol = 5'd8,
    PhProtocol       = 5'd9,
    PhBeforeVersion  = 5'd10,
    PhVersion        = 5'd11,
    PhGotCr          = 5'd12,
    PhLineStart      = 5'd13,
    PhHkey           = 5'd14,
    PhHvalue         = 5'd15,
    PhBlankCr        = 5'd16,
    PhBody           = 5'd17,
    PhComplete       = 5'd18,
    PhInvalid        = 5'd19,
    PhInvalidMethod  = 5'd20,
    PhInvalidUrl     = 5'd21
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       body_flag;
  logic       body_flag_next;
  logic [7:0] c;
  logic       crlf_blank;

  assign c          = data_byte;
  assign crlf_blank = (c == hrbp_pkg::ChCr) || (c == hrbp_pkg::ChLf) || hrbp_pkg::is_blank(c);

  // Decode the byte against the current phase
  always_comb begin
    phase_next     = phase;
    body_flag_next = body_flag;
    byte_field     = hrbp_pkg::FieldNone;
    field_closed   = hrbp_pkg::FieldNone;
    hdr_ctl        = '0;
    if (restart) begin
      phase_next      = PhStart;
      body_flag_next  = 1'b0;
      hdr_ctl.restart = 1'b1;
    end else begin
      unique case (phase)
        PhStart: begin
          if (crlf_blank) begin
            phase_next = PhStart;
          end else if (hrbp_pkg::is_upper(c)) begin
            phase_next = PhMethod;
            byte_field = hrbp_pkg::FieldMethod;
          end else begin
            phase_next = PhInvalid;
          end
        end
        PhMethod: begin
          if (hrbp_pkg::is_upper(c)) begin
            byte_field = hrbp_pkg::FieldMethod;
          end else if (hrbp_pkg::is_blank(c)) begin
            field_closed = hrbp_pkg::FieldMethod;
            phase_next   = PhBeforeUrl;
          end else begin
            phase_next = PhInvalidMethod;
          end
        end
        PhBeforeUrl: begin
          if (c == hrbp_pkg::ChSlash) begin
            phase_next = PhUrl;
            byte_field = hrbp_pkg::FieldUrl;
          end else if (!hrbp_pkg::is_blank(c)) begin
            phase_next = PhInvalidUrl;
          end
        end
        PhUrl: begin
          if (c == hrbp_pkg::ChQuery) begin
            field_closed = hrbp_pkg::FieldUrl;
            phase_next   = PhBeforeQkey;
          end else if (hrbp_pkg::is_blank(c)) begin
            field_closed = hrbp_pkg::FieldUrl;
            phase_next   = PhBeforeProtocol;
          end else begin
            byte_field = hrbp_pkg::FieldUrl;
          end
        end
        PhBeforeQkey: begin
          if (crlf_blank) begin
            phase_next = PhInvalid;
          end else begin
            phase_next = PhQkey;
            byte_field = hrbp_pkg::FieldQkey;
          end
        end
        PhQkey: begin
          if (c == hrbp_pkg::ChEqual) begin
            field_closed = hrbp_pkg::FieldQkey;
            phase_next   = PhBeforeQvalue;
          end else if (hrbp_pkg::is_blank(c)) begin
            phase_next = PhInvalid;
          end else begin
            byte_field = hrbp_pkg::FieldQkey;
          end
        end
        PhBeforeQvalue: begin
          if (crlf_blank) begin
            phase_next = PhInvalid;
          end else begin
            phase_next = PhQvalue;
            byte_field = hrbp_pkg::FieldQvalue;
          end
        end
        PhQvalue: begin
          if (c == hrbp_pkg::ChAmp) begin
            field_closed = hrbp_pkg::FieldQvalue;
            phase_next   = PhBeforeQkey;
          end else if (hrbp_pkg::is_blank(c)) begin
            field_closed = hrbp_pkg::FieldQvalue;
            phase_next   = PhBeforeProtocol;
          end else begin
            byte_field = hrbp_pkg::FieldQvalue;
          end
        end
        PhBeforeProtocol: begin
          if (!hrbp_pkg::is_blank(c)) begin
            phase_next = PhProtocol;
            byte_field = hrbp_pkg::FieldProtocol;
          end
        end
        PhProtocol: begin
          if (c == hrbp_pkg::ChSlash) begin
            field_closed = hrbp_pkg::FieldProtocol;
            phase_next   = PhBeforeVersion;
          end else begin
            byte_field = hrbp_pkg::FieldProtocol;
          end
        end
        PhBeforeVersion: begin
          if (hrbp_pkg::is_digit(c)) begin
            phase_next = PhVersion;
            byte_field = hrbp_pkg::FieldVersion;
          end else begin
            phase_next = PhInvalid;
          end
        end
        PhVersion: begin
          if (hrbp_pkg::is_digit(c) || (c == hrbp_pkg::ChDot)) begin
            byte_field = hrbp_pkg::FieldVersion;
          end else if (c == hrbp_pkg::ChCr) begin
            field_closed = hrbp_pkg::FieldVersion;
            phase_next   = PhGotCr;
          end else begin
            phase_next = PhInvalid;
          end
        end
        PhGotCr: begin
          phase_next = (c == hrbp_pkg::ChLf) ? PhLineStart : PhInvalid;
        end
        PhLineStart: begin
          if (c == hrbp_pkg::ChCr) begin
            phase_next = PhBlankCr;
          end else if (hrbp_pkg::is_blank(c)) begin
            phase_next = PhInvalid;
          end else begin
            phase_next        = PhHkey;
            byte_field        = hrbp_pkg::FieldHkey;
            hdr_ctl.key_first = 1'b1;
          end
        end
        PhHkey: begin
          if (c == hrbp_pkg::ChColon) begin
            field_closed      = hrbp_pkg::FieldHkey;
            phase_next        = PhHvalue;
            hdr_ctl.key_colon = 1'b1;
          end else begin
            byte_field       = hrbp_pkg::FieldHkey;
            hdr_ctl.key_char = 1'b1;
          end
        end
        PhHvalue: begin
          if (c == hrbp_pkg::ChCr) begin
            field_closed = hrbp_pkg::FieldHvalue;
            phase_next   = PhGotCr;
          end else begin
            byte_field         = hrbp_pkg::FieldHvalue;
            hdr_ctl.value_char = 1'b1;
          end
        end
        PhBlankCr: begin
          // Decide on a body at the end of the blank line
          if (c == hrbp_pkg::ChLf) begin
            body_flag_next = hdr_stat.seen ? hdr_stat.positive : !buffer_last;
            phase_next     = body_flag_next ? PhBody : PhComplete;
          end else begin
            phase_next = PhInvalid;
          end
        end
        PhBody: begin
          byte_field = hrbp_pkg::FieldBody;
          if (buffer_last) phase_next = PhComplete;
        end
        PhComplete:      phase_next = PhComplete;
        PhInvalid:       phase_next = PhInvalid;
        PhInvalidMethod: phase_next = PhInvalid;
        PhInvalidUrl:    phase_next = PhInvalid;
        default:         phase_next = PhInvalid;
      endcase
    end
  end

  // Map the phase after this byte to a status code
  always_comb begin
    case (phase_next)
      PhComplete:      parse_status = hrbp_pkg::StatusComplete;
      PhInvalid:       parse_status = hrbp_pkg::StatusInvalid;
      PhInvalidMethod: parse_status = hrbp_pkg::StatusInvalidMethod;
      PhInvalidUrl:    parse_status = hrbp_pkg::StatusInvalidUrl;
      default:         parse_status = hrbp_pkg::StatusParsing;
    endcase
  end

  assign body_follows = body_flag_next;

  // Hold phase and body flag between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PhStart;
      body_flag <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      body_flag <= body_flag_next;
    end
  end

endmodule

// File: rtl/http_request_byte_parser_unit.sv
// Top level of the HTTP request byte parser: input register, parse logic, result register.
// Depends on hrbp_pkg, hrbp_phase and hrbp_hdr_track.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------------
//   in       | in_valid / in_stall  | action, data_byte, buffer_last
//   out      | out_valid / out_stall| byte_echo, byte_field, field_closed,
//            |                      | parse_status, body_follows
//
// One beat per cycle sustained while the output does not stall; a byte is held in the input
// register, then loaded into the result register once that register is free to take it.
// Reset is synchronous and returns the parser to the start of a request.
// A stall on the output holds the result register; the input register takes at most one
// more beat, and the input then stalls until the result is taken.

module http_request_byte_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       buffer_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_echo,
  output logic [3:0] byte_field,
  output logic [3:0] field_closed,
  output logic [2:0] parse_status,
  output logic       body_follows
);

  logic                s_valid;
  logic                s_action;
  logic [7:0]          s_byte;
  logic                s_last;
  logic                out_free;
  logic                s_fire;
  logic                in_fire;
  hrbp_pkg::hdr_ctl_t  hdr_ctl;
  hrbp_pkg::hdr_stat_t hdr_stat;
  logic [3:0]          field_c;
  logic [3:0]          closed_c;
  logic [2:0]          status_c;
  logic                body_c;

  assign out_free = !out_valid || !out_stall;
  assign s_fire   = s_valid && out_free;
  assign in_stall = s_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_fire) begin
      s_valid <= 1'b1;
    end else if (s_fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_action <= action;
      s_byte   <= data_byte;
      s_last   <= buffer_last;
    end
  end

  hrbp_phase u_phase (
    .clk          (clk),
    .rst          (rst),
    .fire         (s_fire),
    .restart      (s_action),
    .data_byte    (s_byte),
    .buffer_last  (s_last),
    .hdr_stat     (hdr_stat),
    .hdr_ctl      (hdr_ctl),
    .byte_field   (field_c),
    .field_closed (closed_c),
    .parse_status (status_c),
    .body_follows (body_c)
  );

  hrbp_hdr_track u_hdr (
    .clk       (clk),
    .rst       (rst),
    .fire      (s_fire),
    .data_byte (s_byte),
    .ctl       (hdr_ctl),
    .stat      (hdr_stat)
  );

  // Load the result register, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      byte_echo    <= s_byte;
      byte_field   <= field_c;
      field_closed <= closed_c;
      parse_status <= status_c;
      body_follows <= body_c;
    end
  end

  // A byte is either part of a field or a delimiter, never both
  a_field_or_delim: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_field != hrbp_pkg::FieldNone) |-> field_closed == hrbp_pkg::FieldNone)
    else $error("byte tagged as field and delimiter");

  // Invalid states tag nothing
  a_invalid_untagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && (parse_status != hrbp_pkg::StatusParsing) &&
    (parse_status != hrbp_pkg::StatusComplete)
    |-> (byte_field == hrbp_pkg::FieldNone) && (field_closed == hrbp_pkg::FieldNone))
    else $error("field tag during invalid status");

  // Body bytes only after the blank line chose a body
  a_body_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_field == hrbp_pkg::FieldBody) |-> body_follows)
    else $error("body byte without body flag");

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule
